>>> rtl/core/sirad_pkg.sv
// shared types and constants of the radix digit converter
`default_nettype none

package sirad_pkg;

   localparam int ALPHA_SLOTS    = 16;
   localparam int CHAR_BITS      = 8;
   localparam int RADIX_BITS     = 5;
   localparam int DIGIT_BITS     = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 64;
   localparam int DIV_STEP_BITS  = 8;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALPHA_LOW  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALPHA_HIGH = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALPHA_LEN  = 2'd2;

   localparam logic [CHAR_BITS-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'h20;

   typedef struct packed {
      logic [ALPHA_SLOTS-1:0][CHAR_BITS-1:0] chars;
      logic [RADIX_BITS-1:0]                 length;
   } cfg_type;

endpackage

`default_nettype wire

>>> rtl/core/sirad_channels.sv
// request and response channel interfaces of the radix digit converter
`default_nettype none

interface sirad_req_if #(
   parameter int VALUE_BITS = 32
) ();
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface sirad_rsp_if ();
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       is_last;

   modport source (output valid, output out_char, output is_last, input ready);
   modport sink (input valid, input out_char, input is_last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/signed_integer_to_radix_digits.sv
// top level of the signed integer to radix digit text converter
//
//  channel   dir  handshake          payload
//  req_ch    in   valid/ready        value (VALUE_BITS, signed)
//  rsp_ch    out  valid/ready        out_char (8), is_last (1)
//  csr_*     in   csr_wr_en strobe   csr_index (2), csr_wdata (64)
//
// the divider forms each digit from the whole value, 8 quotient bits a cycle
// each character then passes through the digit memory read and emit states, the sign first
// reset is synchronous; the digit memory needs no clearing pass
// a stalled response holds the back stage while the front and queue keep taking items until full
`default_nettype none

module signed_integer_to_radix_digits #(
   parameter int MAX_RADIX  = 16,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   sirad_req_if.sink                                req_ch,
   sirad_rsp_if.source                              rsp_ch,
   input  wire logic                                csr_wr_en,
   input  wire logic [sirad_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [sirad_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import sirad_pkg::*;

   logic [CSR_DATA_BITS-1:0] alpha_low_ff, alpha_high_ff;
   logic [RADIX_BITS-1:0]    alpha_len_ff;
   cfg_type                  cfg;

   logic                  push_valid, push_ready, push_neg;
   logic [VALUE_BITS-1:0] push_mag;
   logic                  pop_valid, pop_ready;
   logic [VALUE_BITS:0]   pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_low_ff  <= '0;
         alpha_high_ff <= '0;
         alpha_len_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ALPHA_LOW:  alpha_low_ff  <= csr_wdata;
            CSR_ALPHA_HIGH: alpha_high_ff <= csr_wdata;
            CSR_ALPHA_LEN:  alpha_len_ff  <= csr_wdata[RADIX_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.chars  = {alpha_high_ff, alpha_low_ff};
   assign cfg.length = alpha_len_ff;

   sirad_front #(
      .MAX_RADIX  (MAX_RADIX),
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .cfg        (cfg),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_neg   (push_neg),
      .push_mag   (push_mag)
   );

   sirad_queue #(
      .WIDTH (VALUE_BITS + 1)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_neg, push_mag}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   sirad_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

>>> rtl/core/sirad_front.sv
// front stage: takes items, checks the alphabet, drops items if it is invalid, forms sign and magnitude
`default_nettype none

module sirad_front #(
   parameter int MAX_RADIX  = 16,
   parameter int VALUE_BITS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   sirad_req_if.sink              req_ch,
   input  wire sirad_pkg::cfg_type cfg,
   output logic                   push_valid,
   input  wire logic              push_ready,
   output logic                   push_neg,
   output logic [VALUE_BITS-1:0]  push_mag
);
   import sirad_pkg::*;

   logic                  front_valid_ff, front_valid_in;
   logic [VALUE_BITS-1:0] front_value_ff;
   logic                  ok_ff, ok_in;
   logic                  consume;

   always_comb begin
      ok_in = (cfg.length >= RADIX_BITS'(2)) && (cfg.length <= RADIX_BITS'(MAX_RADIX));
      for (int a = 0; a < MAX_RADIX; a++) begin
         if (RADIX_BITS'(a) < cfg.length) begin
            if (cfg.chars[a] == CHAR_PLUS || cfg.chars[a] == CHAR_MINUS ||
                cfg.chars[a] == CHAR_SPACE) begin
               ok_in = 1'b0;
            end
            for (int b = a + 1; b < MAX_RADIX; b++) begin
               if (RADIX_BITS'(b) < cfg.length && cfg.chars[a] == cfg.chars[b]) begin
                  ok_in = 1'b0;
               end
            end
         end
      end
   end

   assign consume      = front_valid_ff && (!ok_ff || push_ready);
   assign req_ch.ready = !front_valid_ff || consume;
   assign push_valid   = front_valid_ff && ok_ff;
   assign push_neg     = front_value_ff[VALUE_BITS-1];
   assign push_mag     = push_neg ? (~front_value_ff + 1'b1) : front_value_ff;

   always_comb begin
      front_valid_in = front_valid_ff;
      if (req_ch.valid && req_ch.ready) begin
         front_valid_in = 1'b1;
      end else if (consume) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
         ok_ff          <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
         ok_ff          <= ok_in;
      end
      if (req_ch.valid && req_ch.ready) begin
         front_value_ff <= req_ch.value;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/sirad_queue.sv
// two-entry queue between front and back stages
`default_nettype none

module sirad_queue #(
   parameter int WIDTH = 33
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);

   logic [1:0][WIDTH-1:0] entry_ff;
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            fill_ff, fill_in;
   logic                  do_push, do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/sirad_back.sv
// back stage: digit divider, digit memory and character output
`default_nettype none

module sirad_back #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sirad_pkg::cfg_type    cfg,
   input  wire logic                  pop_valid,
   output logic                       pop_ready,
   input  wire logic [VALUE_BITS:0]   pop_data,
   sirad_rsp_if.source                rsp_ch
);
   import sirad_pkg::*;

   localparam int STEPS = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
   localparam int WB    = STEPS * DIV_STEP_BITS;
   localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int AW    = $clog2(VALUE_BITS);
   localparam int CW    = $clog2(VALUE_BITS + 1);

   localparam logic [2:0] B_IDLE = 3'd0;
   localparam logic [2:0] B_DIV  = 3'd1;
   localparam logic [2:0] B_SIGN = 3'd2;
   localparam logic [2:0] B_READ = 3'd3;
   localparam logic [2:0] B_EMIT = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [WB-1:0]         work_ff, work_in;
   logic [DIGIT_BITS-1:0] rem_ff, rem_in;
   logic [SW-1:0]         step_ff, step_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]  rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [DIGIT_BITS-1:0] digit_mem [VALUE_BITS];
   logic [DIGIT_BITS-1:0] rd_digit_ff;
   logic [CW-1:0]         cnt_m1;
   logic [AW-1:0]         rd_idx;
   logic [AW-1:0]         wr_idx;
   logic                  mem_we;

   logic [DIV_STEP_BITS-1:0] top_byte;
   logic [DIV_STEP_BITS-1:0] q_byte;
   logic [DIGIT_BITS-1:0]    div_rem;
   logic [RADIX_BITS-1:0]    trial;
   logic [WB-1:0]            quot;
   logic                     out_free;

   assign top_byte = work_ff[WB-1 -: DIV_STEP_BITS];

   always_comb begin
      div_rem = rem_ff;
      q_byte  = '0;
      trial   = '0;
      for (int k = DIV_STEP_BITS - 1; k >= 0; k--) begin
         trial = {div_rem, top_byte[k]};
         if (trial >= cfg.length) begin
            q_byte[k] = 1'b1;
            div_rem   = DIGIT_BITS'(trial - cfg.length);
         end else begin
            div_rem = trial[DIGIT_BITS-1:0];
         end
      end
   end

   assign quot     = (work_ff << DIV_STEP_BITS) | WB'(q_byte);
   assign cnt_m1   = cnt_ff - 1'b1;
   assign rd_idx   = cnt_m1[AW-1:0];
   assign wr_idx   = cnt_ff[AW-1:0];
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   assign pop_ready       = (state_ff == B_IDLE);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_char = rsp_char_ff;
   assign rsp_ch.is_last  = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      mem_we       = 1'b0;
      rsp_valid_in = rsp_ch.ready ? 1'b0 : rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               neg_in   = pop_data[VALUE_BITS];
               work_in  = WB'(pop_data[VALUE_BITS-1:0]);
               rem_in   = '0;
               step_in  = '0;
               cnt_in   = '0;
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            work_in = quot;
            rem_in  = div_rem;
            step_in = step_ff + 1'b1;
            if (step_ff == SW'(STEPS - 1)) begin
               mem_we  = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
               rem_in  = '0;
               step_in = '0;
               if (quot == '0 || cnt_in == CW'(VALUE_BITS)) begin
                  state_in = neg_ff ? B_SIGN : B_READ;
               end
            end
         end
         B_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = B_READ;
            end
         end
         B_READ: begin
            state_in = B_EMIT;
         end
         B_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = cfg.chars[rd_digit_ff];
               rsp_last_in  = (cnt_ff == CW'(1));
               cnt_in       = cnt_m1;
               state_in     = (cnt_ff == CW'(1)) ? B_IDLE : B_READ;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         digit_mem[wr_idx] <= div_rem;
      end
      rd_digit_ff <= digit_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         step_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      work_ff     <= work_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

`default_nettype wire

>>> verif/signed_integer_to_radix_digits_tb.sv
// testbench of the signed integer to radix digit text converter
module signed_integer_to_radix_digits_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sirad_pkg::*;

   localparam int VALUE_BITS   = 32;
   localparam int MAX_RADIX    = 16;
   localparam int QUIET_CYCLES = 400;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int PHASE_ITEMS  = 54;
   localparam int HOLD_CYCLES  = 500;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;

   localparam logic [63:0] DEC_LOW  = 64'h3736_3534_3332_3130;
   localparam logic [63:0] HEX_HIGH = 64'h4645_4443_4241_3938;

   typedef struct packed {
      logic [CHAR_BITS-1:0] ch;
      logic                 last;
   } text_char_type;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   sirad_req_if #(.VALUE_BITS(VALUE_BITS)) req_ch ();
   sirad_rsp_if rsp_ch ();

   signed_integer_to_radix_digits #(
      .MAX_RADIX (MAX_RADIX),
      .VALUE_BITS(VALUE_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   cfg_type       alpha_cfg = '0;
   text_char_type expected_chars[$];
   int         error_count    = 0;
   int         items_sent     = 0;
   int         chars_checked  = 0;
   int         alphabets_set  = 0;
   int         cycle_count    = 0;
   int         hold_left      = 0;
   bit         no_idle        = 1'b0;
   logic [MAX_RADIX:0] radix_seen = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("mismatch: %s", msg);
   endfunction

   function automatic bit alphabet_valid();
      int len;
      len = int'(alpha_cfg.length);
      if (len < 2 || len > MAX_RADIX) return 1'b0;
      for (int a = 0; a < len; a++) begin
         if (alpha_cfg.chars[a] == CHAR_PLUS || alpha_cfg.chars[a] == CHAR_MINUS ||
             alpha_cfg.chars[a] == CHAR_SPACE) return 1'b0;
         for (int b = a + 1; b < len; b++) begin
            if (alpha_cfg.chars[a] == alpha_cfg.chars[b]) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // digits are formed least significant first, then emitted in reverse
   function automatic void predict_text(input logic signed [VALUE_BITS-1:0] value);
      logic [VALUE_BITS-1:0] mag;
      logic [VALUE_BITS-1:0] radix;
      logic [DIGIT_BITS-1:0] digits [VALUE_BITS];
      int                    count;
      if (!alphabet_valid()) return;
      radix = VALUE_BITS'(alpha_cfg.length);
      mag   = value[VALUE_BITS-1] ? -value : value;
      count = 0;
      do begin
         digits[count] = DIGIT_BITS'(mag % radix);
         mag = mag / radix;
         count++;
      end while (mag != 0 && count < VALUE_BITS);
      if (value[VALUE_BITS-1]) expected_chars.push_back(text_char_type'{CHAR_MINUS, 1'b0});
      while (count > 0) begin
         count--;
         expected_chars.push_back(text_char_type'{alpha_cfg.chars[digits[count]],
                                                  count == 0});
      end
   endfunction

   always @(posedge clock) begin : check_chars
      text_char_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         chars_checked++;
         if (expected_chars.size() == 0) begin
            note_error($sformatf("unexpected char %h last %b", rsp_ch.out_char,
                                 rsp_ch.is_last));
         end else begin
            want = expected_chars.pop_front();
            if (rsp_ch.out_char !== want.ch || rsp_ch.is_last !== want.last)
               note_error($sformatf("expected char %h last %b, got char %h last %b",
                                    want.ch, want.last, rsp_ch.out_char, rsp_ch.is_last));
         end
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= no_idle || ($urandom_range(99) >= 8);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d chars still expected", cycle_count,
                  expected_chars.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_value(input logic signed [VALUE_BITS-1:0] value);
      while (!no_idle && $urandom_range(99) < 8) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
      predict_text(value);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_ALPHA_LOW:  alpha_cfg.chars[7:0]  = data;
         CSR_ALPHA_HIGH: alpha_cfg.chars[15:8] = data;
         CSR_ALPHA_LEN:  alpha_cfg.length      = data[RADIX_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic set_alphabet(input logic [63:0] low, input logic [63:0] high,
                               input logic [63:0] len_word);
      write_csr(CSR_ALPHA_LOW, low);
      write_csr(CSR_ALPHA_HIGH, high);
      write_csr(CSR_ALPHA_LEN, len_word);
      alphabets_set++;
      if (alphabet_valid()) radix_seen[alpha_cfg.length] = 1'b1;
   endtask

   function automatic logic signed [VALUE_BITS-1:0] random_value(input int radix);
      logic [VALUE_BITS-1:0] v;
      longint                p;
      case ($urandom_range(9))
         0, 1, 2, 3: v = $urandom;
         4, 5:       v = $urandom_range(radix * radix * radix);
         6:          v = $urandom >> $urandom_range(31);
         7:          v = -$urandom_range(radix * radix);
         8: begin
            case ($urandom_range(3))
               0: v = 32'h8000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'h0000_0000;
               default: v = 32'hFFFF_FFFF;
            endcase
         end
         default: begin
            p = 1;
            repeat ($urandom_range(1, 31)) if (p * radix < 64'h8000_0000) p = p * radix;
            v = VALUE_BITS'(p + $urandom_range(2) - 1);
            if ($urandom_range(1)) v = -v;
         end
      endcase
      return v;
   endfunction

   // random alphabet of the given radix, optionally made invalid in one way
   task automatic run_phase(input int radix, input int items, input bit broken);
      logic [CHAR_BITS-1:0]             chars [ALPHA_SLOTS];
      logic [ALPHA_SLOTS*CHAR_BITS-1:0] packed_chars;
      logic [63:0]                      len_word;
      logic [CHAR_BITS-1:0]             c;
      bit                               clash;
      int                               pos;
      for (int i = 0; i < ALPHA_SLOTS; i++) begin
         if (i < radix) begin
            do begin
               c = CHAR_BITS'($urandom_range(255));
               clash = (c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_SPACE);
               for (int j = 0; j < i; j++) if (chars[j] == c) clash = 1'b1;
            end while (clash);
            chars[i] = c;
         end else begin
            chars[i] = CHAR_BITS'($urandom_range(255));
         end
      end
      len_word = {$urandom, $urandom};
      len_word[RADIX_BITS-1:0] = RADIX_BITS'(radix);
      if (broken) begin
         case ($urandom_range(2))
            0: begin
               pos = $urandom_range(1, radix - 1);
               chars[pos] = chars[$urandom_range(pos - 1)];
            end
            1: begin
               case ($urandom_range(2))
                  0: chars[$urandom_range(radix - 1)] = CHAR_PLUS;
                  1: chars[$urandom_range(radix - 1)] = CHAR_MINUS;
                  default: chars[$urandom_range(radix - 1)] = CHAR_SPACE;
               endcase
            end
            default: len_word[RADIX_BITS-1:0] = RADIX_BITS'($urandom_range(1) ?
                                                  $urandom_range(1) :
                                                  $urandom_range(17, 31));
         endcase
      end
      for (int i = 0; i < ALPHA_SLOTS; i++) packed_chars[i*CHAR_BITS +: CHAR_BITS] = chars[i];
      set_alphabet(packed_chars[63:0], packed_chars[127:64], len_word);
      repeat (items) send_value(random_value(radix));
      wait_idle();
   endtask

   // alphabet length is zero after reset, so nothing comes out
   task automatic test_reset_alphabet();
      send_value(32'sd12345);
      send_value(32'hFFFF_FFFF);
      wait_idle();
   endtask

   // unused alphabet bytes hold sign and space characters
   task automatic test_decimal_extremes();
      logic signed [VALUE_BITS-1:0] picks [7] = '{32'd0, 32'd7, -32'sd9, 32'd10,
                                                  32'h7FFF_FFFF, 32'h8000_0000,
                                                  32'hFFFF_FFFF};
      set_alphabet(DEC_LOW, 64'h2B2D_202B_2D20_3938, 64'd10);
      foreach (picks[i]) send_value(picks[i]);
      wait_idle();
   endtask

   task automatic test_binary_zero_byte();
      set_alphabet(64'h0000_0000_0000_0100, 64'd0, 64'd2);
      send_value(32'd0);
      send_value(32'h8000_0000);
      send_value(32'h7FFF_FFFF);
      wait_idle();
   endtask

   // full width length word and a write to the unused index
   task automatic test_hex_and_unused_index();
      set_alphabet(DEC_LOW, HEX_HIGH, 64'hFFFF_FFFF_FFFF_FFF0);
      write_csr(CSR_UNUSED, 64'd3);
      send_value(32'hDEAD_BEEF);
      send_value(32'd255);
      wait_idle();
   endtask

   task automatic test_invalid_alphabets();
      logic [63:0] lows  [9] = '{DEC_LOW, DEC_LOW, DEC_LOW, DEC_LOW, DEC_LOW,
                                 64'h3736_3534_3332_312D, DEC_LOW,
                                 64'h3436_3534_3332_3130, DEC_LOW};
      logic [63:0] highs [9] = '{64'd0, 64'd0, HEX_HIGH, HEX_HIGH, 64'h0000_0000_0000_2B38,
                                 64'd0, 64'h4645_4420_4241_3938, 64'd0,
                                 64'h3045_4443_4241_3938};
      logic [63:0] lens  [9] = '{64'd0, 64'd1, 64'd17, 64'hFFFF_FFFF_FFFF_FFFF, 64'd10,
                                 64'd8, 64'd16, 64'd8, 64'd16};
      foreach (lows[i]) begin
         set_alphabet(lows[i], highs[i], lens[i]);
         send_value(random_value(10));
         wait_idle();
      end
   endtask

   task automatic test_random_alphabets();
      run_phase(2, PHASE_ITEMS, 1'b0);
      run_phase(MAX_RADIX, PHASE_ITEMS, 1'b0);
      repeat (4) run_phase($urandom_range(2, MAX_RADIX), PHASE_ITEMS, 1'b0);
   endtask

   task automatic test_back_to_back();
      no_idle = 1'b1;
      run_phase($urandom_range(2, MAX_RADIX), PHASE_ITEMS, 1'b0);
      no_idle = 1'b0;
   endtask

   // response side stalls while items keep coming, so the input backs up
   task automatic test_receiver_hold_off();
      hold_left = HOLD_CYCLES;
      run_phase($urandom_range(2, MAX_RADIX), PHASE_ITEMS, 1'b0);
   endtask

   task automatic test_random_invalid();
      repeat (3) run_phase($urandom_range(2, MAX_RADIX), 8, 1'b1);
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      rsp_ch.ready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_alphabet();
      test_decimal_extremes();
      test_binary_zero_byte();
      test_hex_and_unused_index();
      test_invalid_alphabets();
      test_random_alphabets();
      test_back_to_back();
      test_receiver_hold_off();
      test_random_invalid();
      $display("converted %0d numbers under %0d alphabet settings, %0d chars checked",
               items_sent, alphabets_set, chars_checked);
      $display("radices seen (bit per radix): %b, mismatches: %0d", radix_seen, error_count);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/sirad_pkg.sv
rtl/core/sirad_channels.sv
rtl/core/sirad_front.sv
rtl/core/sirad_queue.sv
rtl/core/sirad_back.sv
rtl/core/signed_integer_to_radix_digits.sv
verif/signed_integer_to_radix_digits_tb.sv
